// File: src/maxout_layer_forward_macros.svh
// Assertion macros for the maxout block
`ifndef MAXOUT_LAYER_FORWARD_MACROS_SVH
`define MAXOUT_LAYER_FORWARD_MACROS_SVH
`ifndef SYNTH
`define MLF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLF_ASSERT(label, clk, rst_n, prop, msg)
`define MLF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: src/mlf_pkg.sv
package mlf_pkg;
    localparam int IN_DIM_DEF  = 64;
    localparam int OUT_DIM_DEF = 32;
    localparam int PIECES_DEF  = 4;
    localparam int MAX_ROWS    = 32;
    localparam int ACC_W       = 40;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CFG_IN_LEN  = 2'd0;
    localparam logic [1:0] CFG_OUT_LEN = 2'd1;
    localparam logic [1:0] CFG_PIECES  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  piece;
        logic [4:0]  row;
        logic [5:0]  column;
        logic signed [15:0] value;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  out_row;
        logic signed [15:0] max_value;
        logic [1:0]  winning_piece;
        logic        final_row;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_bias;   // start a piece sum with the bias
        logic mac;         // add one product
        logic piece_done;  // compare the finished piece sum
        logic row_done;    // form the result of the row
    } t_dp_cmd;

    function automatic logic signed [15:0] to_q412(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-13:0] q;
        t = a + ACC_W'(2048);
        q = t[ACC_W-1:12];
        if (q > 32767)       to_q412 = 16'sh7fff;
        else if (q < -32768) to_q412 = 16'sh8000;
        else                 to_q412 = q[15:0];
    endfunction
endpackage

// File: src/mlf_stream_if.sv
interface mlf_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/mlf_datapath.sv
`include "maxout_layer_forward_macros.svh"
module mlf_datapath #(
    parameter int IN_DIM  = mlf_pkg::IN_DIM_DEF,
    parameter int OUT_DIM = mlf_pkg::OUT_DIM_DEF,
    parameter int PIECES  = mlf_pkg::PIECES_DEF,
    localparam int CW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1,
    localparam int RW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1,
    localparam int PW = (PIECES > 1) ? $clog2(PIECES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_w,
    input  logic                  i_wr_b,
    input  logic                  i_wr_x,
    input  logic [PW-1:0]         i_wr_p,
    input  logic [RW-1:0]         i_wr_r,
    input  logic [CW-1:0]         i_wr_c,
    input  logic signed [15:0]    i_wr_v,
    input  mlf_pkg::t_dp_cmd      i_cmd,
    input  logic [PW-1:0]         i_p,
    input  logic [RW-1:0]         i_r,
    input  logic [CW-1:0]         i_c,
    output logic signed [15:0]    o_max,
    output logic [PW-1:0]         o_win
);
    localparam int AW = mlf_pkg::ACC_W;
    logic signed [15:0] r_wmem [PIECES][OUT_DIM][IN_DIM];
    logic signed [15:0] r_bmem [PIECES][OUT_DIM];
    logic signed [15:0] r_xbuf [IN_DIM];
    logic signed [15:0] r_w, r_x, r_b;
    logic signed [31:0] r_prod;
    logic               r_prod_v, r_mac_d;
    logic signed [AW-1:0] r_acc, r_best;
    logic [PW-1:0]      r_bestp;
    logic               r_first;

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_wr_w) r_wmem[i_wr_p][i_wr_r][i_wr_c] <= i_wr_v;
        r_w <= r_wmem[i_p][i_r][i_c];
    end
    always_ff @(posedge i_clk) begin
        if (i_wr_b) r_bmem[i_wr_p][i_wr_r] <= i_wr_v;
        r_b <= r_bmem[i_p][i_r];
    end
    always_ff @(posedge i_clk) begin
        if (i_wr_x) r_xbuf[i_wr_c] <= i_wr_v;
        r_x <= r_xbuf[i_c];
    end

    // mac pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_d  <= 1'b0;
            r_prod_v <= 1'b0;
            r_acc    <= '0;
            r_best   <= '0;
            r_bestp  <= '0;
            r_first  <= 1'b1;
            o_max    <= '0;
            o_win    <= '0;
        end else begin
            r_mac_d  <= i_cmd.mac;
            r_prod_v <= r_mac_d;
            if (r_mac_d) r_prod <= r_w * r_x;
            if (i_cmd.load_bias) r_acc <= AW'(r_b) <<< 12;
            else if (r_prod_v)   r_acc <= r_acc + AW'(r_prod);
            if (i_cmd.piece_done) begin
                if (r_first || r_acc > r_best) begin
                    r_best  <= r_acc;
                    r_bestp <= i_p;
                end
                r_first <= 1'b0;
            end
            if (i_cmd.row_done) begin
                o_max   <= mlf_pkg::to_q412(r_best);
                o_win   <= r_bestp;
                r_first <= 1'b1;
            end
        end
    end

    `MLF_ASSERT(a_no_bias_mid_mac, i_clk, i_rst_n, i_cmd.load_bias |-> !r_prod_v,
        "bias load collides with mac")
    `MLF_ASSERT(a_cmd_excl, i_clk, i_rst_n, $countones(i_cmd) <= 1, "commands overlap")
    `MLF_ASSERT(a_done_drained, i_clk, i_rst_n, i_cmd.piece_done |-> !r_prod_v && !r_mac_d,
        "piece closed before products drained")
endmodule

// File: src/mlf_ctrl.sv
`include "maxout_layer_forward_macros.svh"
module mlf_ctrl #(
    parameter int IN_DIM  = mlf_pkg::IN_DIM_DEF,
    parameter int OUT_DIM = mlf_pkg::OUT_DIM_DEF,
    parameter int PIECES  = mlf_pkg::PIECES_DEF,
    localparam int CW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1,
    localparam int RW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1,
    localparam int PW = (PIECES > 1) ? $clog2(PIECES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [6:0]         i_in_len,
    input  logic [5:0]         i_out_len,
    input  logic [2:0]         i_pieces,
    input  logic               i_out_ready,
    output logic               o_busy,
    output logic               o_out_valid,
    output logic               o_final,
    output logic [RW-1:0]      o_out_row,
    output mlf_pkg::t_dp_cmd   o_cmd,
    output logic [PW-1:0]      o_p,
    output logic [RW-1:0]      o_r,
    output logic [CW-1:0]      o_c
);
    localparam logic [2:0] S_IDLE = 3'd0, S_BIAS = 3'd1, S_LOAD = 3'd2, S_MAC = 3'd3,
                           S_DRAIN = 3'd4, S_CMP = 3'd5, S_ROW = 3'd6;
    localparam int NRMAX = (OUT_DIM < mlf_pkg::MAX_ROWS) ? OUT_DIM : mlf_pkg::MAX_ROWS;

    logic [2:0]  r_st, n_st;
    logic [10:0] r_c;
    logic [6:0]  r_r;
    logic [4:0]  r_p;
    logic [1:0]  r_dr;
    logic [10:0] r_ni;
    logic [6:0]  r_no;
    logic [4:0]  r_np;
    logic        r_ov;
    logic [RW-1:0] r_orow;
    logic        r_ofin;
    logic        last_row;
    logic        slot_free;

    function automatic logic [10:0] clampl(input logic [10:0] v, input logic [10:0] hi);
        if (v == '0)    clampl = 11'd1;
        else if (v > hi) clampl = hi;
        else            clampl = v;
    endfunction

    assign o_c = r_c[CW-1:0];
    assign o_r = r_r[RW-1:0];
    assign o_p = r_p[PW-1:0];
    assign o_busy = (r_st != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_final = r_ofin;
    assign o_out_row = r_orow;
    assign last_row = (r_r + 7'd1 == r_no);
    // the output register takes a new row once empty or being taken
    assign slot_free = !r_ov || i_out_ready;

    always_comb begin
        o_cmd = '0;
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_start) n_st = S_BIAS;
            S_BIAS:  n_st = S_LOAD;
            S_LOAD:  begin o_cmd.load_bias = 1'b1; n_st = S_MAC; end
            S_MAC:   begin
                o_cmd.mac = 1'b1;
                if (r_c + 11'd1 == r_ni) n_st = S_DRAIN;
            end
            S_DRAIN: if (r_dr == 2'd3) n_st = S_CMP;
            S_CMP:   begin
                o_cmd.piece_done = 1'b1;
                n_st = (r_p + 5'd1 == r_np) ? S_ROW : S_BIAS;
            end
            S_ROW:   if (slot_free) begin
                o_cmd.row_done = 1'b1;
                n_st = last_row ? S_IDLE : S_BIAS;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_c <= '0; r_r <= '0; r_p <= '0; r_dr <= '0;
            r_ni <= 11'd1; r_no <= 7'd1; r_np <= 5'd1;
            r_ov <= 1'b0; r_orow <= '0; r_ofin <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_ROW && slot_free) begin
                r_ov   <= 1'b1;
                r_orow <= r_r[RW-1:0];
                r_ofin <= last_row;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    r_ni <= clampl(11'(i_in_len), 11'(IN_DIM));
                    r_no <= 7'(clampl(11'(i_out_len), 11'(NRMAX)));
                    r_np <= 5'(clampl(11'(i_pieces), 11'(PIECES)));
                    r_r <= '0; r_p <= '0; r_c <= '0;
                end
                S_MAC: begin
                    r_c <= r_c + 11'd1;
                    r_dr <= '0;
                end
                S_DRAIN: r_dr <= r_dr + 2'd1;
                S_CMP: begin
                    r_c <= '0;
                    if (r_p + 5'd1 != r_np) r_p <= r_p + 5'd1;
                end
                S_ROW: if (slot_free) begin
                    r_p <= '0;
                    r_r <= r_r + 7'd1;
                end
                default: ;
            endcase
        end
    end

    `MLF_ASSERT(a_row_bound, i_clk, i_rst_n, o_busy |-> r_r < r_no, "row past length")
    `MLF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid,
        "result dropped under stall")
    `MLF_ASSERT(a_col_bound, i_clk, i_rst_n, o_cmd.mac |-> r_c < r_ni, "column past length")
endmodule

// File: src/maxout_layer_forward.sv
// Maxout layer forward pass.
// Input channel carries opcode items: weight writes, bias writes and input
// elements. Writes and input elements are taken one per cycle while idle. An
// input element with last set starts a run, and the input channel stays
// stalled until the last row of the run has been computed.
// For each row and piece the block reads the bias, then one weight and one
// input word per cycle through a single multiply-accumulate unit, then
// drains the read and multiply pipeline and compares the piece sum. Run
// time is set by the one shared MAC and the single weight read port.
// Each output item gives the row, its saturated Q4.12 maximum, the winning
// piece and a flag on the last row. It waits in an output register while the
// receiver stalls; the next row is computed meanwhile and then held back
// until the register is free.
// The user must make configuration writes while idle; the block does not
// enforce this. Synchronous reset returns the lengths to their defaults and
// empties the output register; memory contents are undefined until written.
module maxout_layer_forward #(
    parameter int IN_DIM  = mlf_pkg::IN_DIM_DEF,
    parameter int OUT_DIM = mlf_pkg::OUT_DIM_DEF,
    parameter int PIECES  = mlf_pkg::PIECES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlf_stream_if.sink   in_if,
    mlf_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);
    localparam int CW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int RW = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int PW = (PIECES > 1) ? $clog2(PIECES) : 1;

    logic [6:0] r_in_len;
    logic [5:0] r_out_len;
    logic [2:0] r_pieces;
    logic busy, acc, fin;
    mlf_pkg::t_in_item d;
    mlf_pkg::t_dp_cmd cmd;
    logic [PW-1:0] p; logic [RW-1:0] r; logic [CW-1:0] c;
    logic [RW-1:0] orow;
    logic signed [15:0] mx; logic [PW-1:0] win;
    logic okp, okr, okc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_len <= 7'd64; r_out_len <= 6'd32; r_pieces <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mlf_pkg::CFG_IN_LEN:  r_in_len <= i_cfg_data;
                mlf_pkg::CFG_OUT_LEN: r_out_len <= i_cfg_data[5:0];
                mlf_pkg::CFG_PIECES:  r_pieces <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign d = in_if.data;
    assign in_if.ready = !busy;
    assign acc = in_if.valid && !busy;
    assign okp = 32'(d.piece) < PIECES;
    assign okr = 32'(d.row) < OUT_DIM;
    assign okc = 32'(d.column) < IN_DIM;

    mlf_datapath #(.IN_DIM(IN_DIM), .OUT_DIM(OUT_DIM), .PIECES(PIECES)) u_dp (
        .i_clk, .i_rst_n,
        .i_wr_w(acc && d.opcode == mlf_pkg::OP_WEIGHT && okp && okr && okc),
        .i_wr_b(acc && d.opcode == mlf_pkg::OP_BIAS && okp && okr),
        .i_wr_x(acc && d.opcode == mlf_pkg::OP_INPUT && okc),
        .i_wr_p(PW'(d.piece)), .i_wr_r(RW'(d.row)), .i_wr_c(CW'(d.column)),
        .i_wr_v(d.value), .i_cmd(cmd), .i_p(p), .i_r(r), .i_c(c),
        .o_max(mx), .o_win(win)
    );

    mlf_ctrl #(.IN_DIM(IN_DIM), .OUT_DIM(OUT_DIM), .PIECES(PIECES)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_start(acc && d.opcode == mlf_pkg::OP_INPUT && d.last),
        .i_in_len(r_in_len), .i_out_len(r_out_len), .i_pieces(r_pieces),
        .i_out_ready(out_if.ready), .o_busy(busy), .o_out_valid(out_if.valid),
        .o_final(fin), .o_out_row(orow), .o_cmd(cmd), .o_p(p), .o_r(r), .o_c(c)
    );

    assign out_if.data.out_row = 5'(orow);
    assign out_if.data.max_value = mx;
    assign out_if.data.winning_piece = 2'(win);
    assign out_if.data.final_row = fin;
endmodule
